// File: rtl/plf_pkg.sv
// ----------------------------------------------------------------------------
// plf_pkg : shared types, codes and helpers of the playfair cipher core
// letter codes, action codes, channel words and key square geometry
// ----------------------------------------------------------------------------
`default_nettype none

package plf_pkg;

  // letter codes and square geometry
  localparam int LETTER_W  = 5;
  localparam int SQ_SIDE   = 5;
  localparam int SQ_CELLS  = 25;
  localparam int ALPHA     = 26;
  localparam int SQ_ADDR_W = 5;
  localparam int PL_ADDR_W = 5;

  typedef logic [LETTER_W-1:0] letter_t;

  localparam letter_t CODE_I = 5'd8;
  localparam letter_t CODE_J = 5'd9;
  localparam letter_t CODE_X = 5'd23;

  // input actions
  typedef enum logic [1:0] {
    ACT_KEY    = 2'd0,
    ACT_FINISH = 2'd1,
    ACT_MSG    = 2'd2,
    ACT_END    = 2'd3
  } action_t;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_DECIPHER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD      = 1'd1;

  // channel words
  typedef struct packed {
    action_t action;
    letter_t letter;
  } in_item_t;

  typedef struct packed {
    letter_t out_letter;
    logic    message_last;
  } out_item_t;

  // digraph handed from front to back
  typedef struct packed {
    letter_t a;
    letter_t b;
    logic    last;
    logic    decipher;
  } pair_t;

  // key store write port driven by the front
  typedef struct packed {
    logic                 we;
    logic [SQ_ADDR_W-1:0] sq_addr;
    letter_t              sq_data;
    logic [PL_ADDR_W-1:0] pl_addr;
    logic [SQ_ADDR_W-1:0] pl_data;
  } key_wr_t;

  // back end status seen by the front
  typedef struct packed {
    logic pair_full;
    logic drained;
  } pipe_stat_t;

  // j is folded into i
  function automatic letter_t fold(input letter_t c);
    return (c == CODE_J) ? CODE_I : c;
  endfunction

  // row of a square place, compare chain instead of a divide by five
  function automatic logic [2:0] place_row(input logic [SQ_ADDR_W-1:0] p);
    logic [2:0] r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  // place of a row and column, row times five as shift and add
  function automatic logic [SQ_ADDR_W-1:0] cell_index(input logic [2:0] row,
                                                      input logic [2:0] col);
    return {row, 2'b00} + {2'b00, row} + {2'b00, col};
  endfunction

  function automatic logic [2:0] place_col(input logic [SQ_ADDR_W-1:0] p);
    logic [SQ_ADDR_W-1:0] d;
    d = p - cell_index(place_row(p), 3'd0);
    return d[2:0];
  endfunction

  // step one place along a row or column with wrap, backwards when deciphering
  function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic back);
    logic [2:0] r;
    if (back) r = (v == 3'd0) ? 3'(SQ_SIDE - 1) : v - 3'd1;
    else      r = (v == 3'(SQ_SIDE - 1)) ? 3'd0 : v + 3'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/plf_ram.sv
// ----------------------------------------------------------------------------
// plf_ram : generic single write, single read ram
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module plf_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/plf_fifo.sv
// ----------------------------------------------------------------------------
// plf_fifo : small first-word fall-through queue
// register storage, head word visible while not empty
// ----------------------------------------------------------------------------
`default_nettype none

module plf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           push_data,
  output logic                            full,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           pop_data,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/plf_front.sv
// ----------------------------------------------------------------------------
// plf_front : input stage of the playfair core
// takes input words, builds the key square, pairs message letters
// ----------------------------------------------------------------------------
`default_nettype none

module plf_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_push,
  input  wire plf_pkg::in_item_t                  in_word,
  output logic                                    in_full,
  input  wire logic                               cfg_decipher,
  input  wire logic [plf_pkg::CFG_DATA_W-1:0]     cfg_pad,
  input  wire plf_pkg::pipe_stat_t                stat,
  output logic                                    pair_push,
  output plf_pkg::pair_t                          pair_word,
  output plf_pkg::key_wr_t                        key_wr
);

  typedef enum logic [1:0] {
    F_RUN  = 2'b01,
    F_FILL = 2'b10
  } front_state_t;

  front_state_t                         state_r, state_nxt;
  logic                                 hold_v_r, hold_v_nxt;
  plf_pkg::in_item_t                    hold_r, hold_nxt;
  logic [plf_pkg::ALPHA-1:0]            used_r, used_nxt, used_base;
  logic [plf_pkg::SQ_ADDR_W-1:0]        fill_r, fill_nxt, fill_base;
  logic                                 key_ready_r, key_ready_nxt;
  plf_pkg::letter_t                     held_r, held_nxt;
  logic                                 held_v_r, held_v_nxt;
  plf_pkg::letter_t                     scan_r, scan_nxt;

  plf_pkg::letter_t                     c;
  plf_pkg::letter_t                     pad_eff;
  plf_pkg::letter_t                     place_c;
  logic                                 letter_ok;
  logic                                 exec;
  logic                                 place_go;

  // folded letter of the held word and the pad in use
  assign c         = plf_pkg::fold(hold_r.letter);
  assign letter_ok = (hold_r.letter < plf_pkg::LETTER_W'(plf_pkg::ALPHA));
  assign pad_eff   = plf_pkg::fold((cfg_pad < plf_pkg::CFG_DATA_W'(plf_pkg::ALPHA)) ?
                                   cfg_pad : plf_pkg::CODE_X);

  // the held word leaves this cycle when exec is high
  assign in_full = hold_v_r && !exec;

  always_comb begin
    state_nxt     = state_r;
    hold_v_nxt    = hold_v_r;
    hold_nxt      = hold_r;
    used_nxt      = used_r;
    fill_nxt      = fill_r;
    key_ready_nxt = key_ready_r;
    held_nxt      = held_r;
    held_v_nxt    = held_v_r;
    scan_nxt      = scan_r;
    exec          = 1'b0;
    place_go      = 1'b0;
    place_c       = c;
    used_base     = used_r;
    fill_base     = fill_r;
    pair_push     = 1'b0;
    pair_word     = '{a: held_r, b: c, last: 1'b0, decipher: cfg_decipher};
    key_wr        = '0;

    case (state_r)
      // classify and carry out the held word
      F_RUN: begin
        if (hold_v_r) begin
          case (hold_r.action)
            plf_pkg::ACT_KEY: begin
              if (!letter_ok) begin
                exec = 1'b1;
              end else if (stat.drained) begin
                exec     = 1'b1;
                place_go = 1'b1;
                if (key_ready_r) begin
                  used_base     = '0;
                  fill_base     = '0;
                  key_ready_nxt = 1'b0;
                  held_v_nxt    = 1'b0;
                  held_nxt      = '0;
                end
              end
            end
            plf_pkg::ACT_FINISH: begin
              exec = 1'b1;
              if (!key_ready_r) begin
                state_nxt = F_FILL;
                scan_nxt  = '0;
              end
            end
            plf_pkg::ACT_MSG: begin
              if (!letter_ok || !key_ready_r) begin
                exec = 1'b1;
              end else if (!held_v_r) begin
                exec       = 1'b1;
                held_nxt   = c;
                held_v_nxt = 1'b1;
              end else if (!stat.pair_full) begin
                exec      = 1'b1;
                pair_push = 1'b1;
                if (!cfg_decipher && (held_r == c)) begin
                  pair_word.b = pad_eff;
                  held_nxt    = c;
                end else begin
                  held_v_nxt = 1'b0;
                  held_nxt   = '0;
                end
              end
            end
            plf_pkg::ACT_END: begin
              if (!key_ready_r || !held_v_r) begin
                exec = 1'b1;
              end else if (!stat.pair_full) begin
                exec           = 1'b1;
                pair_push      = 1'b1;
                pair_word.b    = pad_eff;
                pair_word.last = 1'b1;
                held_v_nxt     = 1'b0;
                held_nxt       = '0;
              end
            end
            default: begin
              exec = 1'b1;
            end
          endcase
        end
      end
      // fill the rest of the square, one letter a cycle, j skipped
      F_FILL: begin
        place_c  = scan_r;
        place_go = (scan_r != plf_pkg::CODE_J);
        scan_nxt = scan_r + 1'b1;
        if (scan_r == plf_pkg::LETTER_W'(plf_pkg::ALPHA - 1)) begin
          key_ready_nxt = 1'b1;
          state_nxt     = F_RUN;
        end
      end
      default: begin
        state_nxt = F_RUN;
      end
    endcase

    // place one letter in the square if new and room is left
    if (place_go) begin
      used_nxt = used_base;
      fill_nxt = fill_base;
      if (!used_base[place_c] &&
          (fill_base < plf_pkg::SQ_ADDR_W'(plf_pkg::SQ_CELLS))) begin
        key_wr.we         = 1'b1;
        key_wr.sq_addr    = fill_base;
        key_wr.sq_data    = place_c;
        key_wr.pl_addr    = place_c;
        key_wr.pl_data    = fill_base;
        used_nxt[place_c] = 1'b1;
        fill_nxt          = fill_base + 1'b1;
      end
    end

    // input holding register
    if (in_push && !in_full) begin
      hold_nxt   = in_word;
      hold_v_nxt = 1'b1;
    end else if (exec) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_RUN;
      hold_v_r    <= 1'b0;
      used_r      <= '0;
      fill_r      <= '0;
      key_ready_r <= 1'b0;
      held_r      <= '0;
      held_v_r    <= 1'b0;
      scan_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      hold_v_r    <= hold_v_nxt;
      used_r      <= used_nxt;
      fill_r      <= fill_nxt;
      key_ready_r <= key_ready_nxt;
      held_r      <= held_nxt;
      held_v_r    <= held_v_nxt;
      scan_r      <= scan_nxt;
    end
  end

  // held word payload, no reset
  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/plf_back.sv
// ----------------------------------------------------------------------------
// plf_back : digraph transform stage of the playfair core
// looks up both places, picks the output cells, reads them out in order
// ----------------------------------------------------------------------------
`default_nettype none

module plf_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire plf_pkg::pair_t                    pair_word,
  input  wire logic                              pair_empty,
  output logic                                   pair_pop,
  input  wire logic                              res_room2,
  output logic                                   res_push,
  output plf_pkg::out_item_t                     res_word,
  output logic [plf_pkg::PL_ADDR_W-1:0]          pl_raddr,
  input  wire logic [plf_pkg::SQ_ADDR_W-1:0]     pl_rdata,
  output logic [plf_pkg::SQ_ADDR_W-1:0]          sq_raddr,
  input  wire plf_pkg::letter_t                  sq_rdata,
  output logic                                   idle
);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_PA   = 6'b000010,
    B_PB   = 6'b000100,
    B_SQ1  = 6'b001000,
    B_SQ2  = 6'b010000,
    B_O2   = 6'b100000
  } back_state_t;

  back_state_t                   state_r, state_nxt;
  plf_pkg::pair_t                pair_r, pair_nxt;
  logic [plf_pkg::SQ_ADDR_W-1:0] pa_r, pa_nxt;
  logic [plf_pkg::SQ_ADDR_W-1:0] i2_r, i2_nxt;
  logic [plf_pkg::SQ_ADDR_W-1:0] i1, i2;
  logic [2:0]                    r1, c1, r2, c2;

  assign idle = (state_r == B_IDLE);

  // output cells of the digraph from both places
  always_comb begin
    r1 = plf_pkg::place_row(pa_r);
    c1 = plf_pkg::place_col(pa_r);
    r2 = plf_pkg::place_row(pl_rdata);
    c2 = plf_pkg::place_col(pl_rdata);
    if (r1 == r2) begin
      i1 = plf_pkg::cell_index(r1, plf_pkg::wrap_step(c1, pair_r.decipher));
      i2 = plf_pkg::cell_index(r2, plf_pkg::wrap_step(c2, pair_r.decipher));
    end else if (c1 == c2) begin
      i1 = plf_pkg::cell_index(plf_pkg::wrap_step(r1, pair_r.decipher), c1);
      i2 = plf_pkg::cell_index(plf_pkg::wrap_step(r2, pair_r.decipher), c2);
    end else begin
      i1 = plf_pkg::cell_index(r1, c2);
      i2 = plf_pkg::cell_index(r2, c1);
    end
  end

  // read addresses
  assign pl_raddr = (state_r == B_PB) ? pair_r.b : pair_r.a;
  assign sq_raddr = (state_r == B_SQ1) ? i1 : i2_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    pair_nxt  = pair_r;
    pa_nxt    = pa_r;
    i2_nxt    = i2_r;
    pair_pop  = 1'b0;
    res_push  = 1'b0;
    res_word  = '{out_letter: sq_rdata, message_last: 1'b0};
    case (state_r)
      B_IDLE: begin
        if (!pair_empty && res_room2) begin
          pair_pop  = 1'b1;
          pair_nxt  = pair_word;
          state_nxt = B_PA;
        end
      end
      B_PA: begin
        state_nxt = B_PB;
      end
      B_PB: begin
        pa_nxt    = pl_rdata;
        state_nxt = B_SQ1;
      end
      B_SQ1: begin
        i2_nxt    = i2;
        state_nxt = B_SQ2;
      end
      B_SQ2: begin
        res_push  = 1'b1;
        state_nxt = B_O2;
      end
      B_O2: begin
        res_push              = 1'b1;
        res_word.message_last = pair_r.last;
        state_nxt             = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working payload, no reset
  always_ff @(posedge clk) begin
    pair_r <= pair_nxt;
    pa_r   <= pa_nxt;
    i2_r   <= i2_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/playfair_digraph_cipher_core.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_core : 5x5 playfair key square and digraph cipher
// builds the key square from key letters and transforms message digraphs
// ----------------------------------------------------------------------------
// usage
//   input queue: push a word (action, letter) while full is low. the front
//   takes key letters and message letters one at a time; a key letter waits
//   until every queued digraph has been transformed. key finish fills the
//   square one alphabet letter a cycle; meanwhile the front takes at most
//   one more word and then holds full high.
//   result queue: while empty is low the oldest word is on out_word; pop takes
//   it. each digraph gives two words, message_last set on the second word of
//   a message end.
//   result order: the back end pushes the first word of a digraph from B_SQ2
//   and the second in the next cycle, from B_O2.
//   back end: one digraph at a time through B_PA, B_PB, B_SQ1, B_SQ2 and
//   B_O2 (two place reads and two square reads through single read port
//   rams); it takes the next digraph only back in B_IDLE. with doubled
//   letters every letter closes a digraph.
//   reset: clears the used flags, fill count, key ready flag, held letter and
//   both queues; the square rams keep their contents and need no clearing.
//   stall: the back end starts a digraph only with two free result entries;
//   when the receiver stops popping, the digraph queue and then full back up.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digraph_cipher_core #(
  parameter int PAIR_DEPTH = 2,
  parameter int RES_DEPTH  = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_push,
  input  wire plf_pkg::in_item_t                 in_word,
  output logic                                   in_full,
  output logic                                   out_empty,
  input  wire logic                              out_pop,
  output plf_pkg::out_item_t                     out_word,
  input  wire logic                              cfg_we,
  input  wire logic [plf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [plf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);
  localparam int PAIR_W    = $bits(plf_pkg::pair_t);
  localparam int OUT_W     = $bits(plf_pkg::out_item_t);

  logic                              decipher_r;
  logic [plf_pkg::CFG_DATA_W-1:0]    pad_r;
  plf_pkg::pipe_stat_t               stat;
  plf_pkg::key_wr_t                  key_wr;
  logic                              pair_push, pair_pop, pair_full, pair_empty;
  plf_pkg::pair_t                    pair_in, pair_out;
  logic                              res_push, res_full, res_room2;
  plf_pkg::out_item_t                res_word;
  logic [RES_CNT_W-1:0]              res_count;
  logic [plf_pkg::PL_ADDR_W-1:0]     pl_raddr;
  logic [plf_pkg::SQ_ADDR_W-1:0]     pl_rdata;
  logic [plf_pkg::SQ_ADDR_W-1:0]     sq_raddr;
  plf_pkg::letter_t                  sq_rdata;
  logic                              back_idle;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decipher_r <= 1'b0;
      pad_r      <= plf_pkg::CODE_X;
    end else if (cfg_we) begin
      case (cfg_index)
        plf_pkg::REG_DECIPHER: decipher_r <= cfg_data[0];
        plf_pkg::REG_PAD:      pad_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // back end status for the front
  assign stat.pair_full = pair_full;
  assign stat.drained   = pair_empty && back_idle;
  assign res_room2      = (res_count <= RES_CNT_W'(RES_DEPTH - 2));

  plf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_word      (in_word),
    .in_full      (in_full),
    .cfg_decipher (decipher_r),
    .cfg_pad      (pad_r),
    .stat         (stat),
    .pair_push    (pair_push),
    .pair_word    (pair_in),
    .key_wr       (key_wr)
  );

  // key square, row-major letters
  plf_ram #(
    .WIDTH (plf_pkg::LETTER_W),
    .DEPTH (plf_pkg::SQ_CELLS)
  ) u_square_ram (
    .clk   (clk),
    .we    (key_wr.we),
    .waddr (key_wr.sq_addr),
    .wdata (key_wr.sq_data),
    .raddr (sq_raddr),
    .rdata (sq_rdata)
  );

  // place of each letter in the square
  plf_ram #(
    .WIDTH (plf_pkg::SQ_ADDR_W),
    .DEPTH (plf_pkg::ALPHA)
  ) u_place_ram (
    .clk   (clk),
    .we    (key_wr.we),
    .waddr (key_wr.pl_addr),
    .wdata (key_wr.pl_data),
    .raddr (pl_raddr),
    .rdata (pl_rdata)
  );

  // digraph queue between front and back
  plf_fifo #(
    .WIDTH (PAIR_W),
    .DEPTH (PAIR_DEPTH)
  ) u_pair_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pair_push),
    .push_data (pair_in),
    .full      (pair_full),
    .pop       (pair_pop),
    .pop_data  (pair_out),
    .empty     (pair_empty),
    .count     ()
  );

  plf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pair_word  (pair_out),
    .pair_empty (pair_empty),
    .pair_pop   (pair_pop),
    .res_room2  (res_room2),
    .res_push   (res_push),
    .res_word   (res_word),
    .pl_raddr   (pl_raddr),
    .pl_rdata   (pl_rdata),
    .sq_raddr   (sq_raddr),
    .sq_rdata   (sq_rdata),
    .idle       (back_idle)
  );

  // result queue
  plf_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_word),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_word),
    .empty     (out_empty),
    .count     (res_count)
  );

  // the back end reserves two entries, so a push never meets a full queue
  logic res_overrun;
  assign res_overrun = res_push && res_full;

  always_ff @(posedge clk) begin
    if (rst_n && res_overrun) begin
      $error("result word pushed into full queue");
    end
  end

endmodule

`default_nettype wire

// File: rtl/plf_checker.sv
// ----------------------------------------------------------------------------
// plf_checker : port level checks of the playfair core
// reset state, result word hold and result letter range
// ----------------------------------------------------------------------------
`default_nettype none

module plf_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_full,
  input wire logic               out_empty,
  input wire logic               out_pop,
  input wire plf_pkg::out_item_t out_word
);

  // both queues are clear after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not clear after reset");

  // a waiting result word holds until popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_word)))
    else $error("result word changed before pop");

  // every result letter comes from the square: a letter code other than j
  a_out_letter: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_word.out_letter != plf_pkg::CODE_J) &&
                    (out_word.out_letter < plf_pkg::LETTER_W'(plf_pkg::ALPHA))))
    else $error("result letter outside the square alphabet");

endmodule

bind playfair_digraph_cipher_core plf_checker u_plf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_word  (out_word)
);

`default_nettype wire

// File: test/playfair_digraph_cipher_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_core_tb : self-checking bench of the playfair core
// builds key squares from key words and runs message words through the core in
// both cipher directions. A predictor models the square, the held letter and
// the registers; every result word is compared field by field in order.
// ----------------------------------------------------------------------------

module playfair_digraph_cipher_core_tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 48;
  localparam int TARGET_WORDS  = 750;
  localparam int IDLE_PCT      = 18;

  // a few letter codes for the directed part
  localparam plf_pkg::letter_t LT_A      = 5'd0;
  localparam plf_pkg::letter_t LT_B      = 5'd1;
  localparam plf_pkg::letter_t LT_C      = 5'd2;
  localparam plf_pkg::letter_t LT_P      = 5'd15;
  localparam plf_pkg::letter_t LT_Z      = 5'd25;
  localparam plf_pkg::letter_t LT_OUT_LO = 5'd26;
  localparam plf_pkg::letter_t LT_OUT_HI = 5'd31;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_push   = 1'b0;
  plf_pkg::in_item_t              in_word   = '0;
  logic                           in_full;
  logic                           out_empty;
  logic                           out_pop   = 1'b0;
  plf_pkg::out_item_t             out_word;
  logic                           cfg_we    = 1'b0;
  logic [plf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [plf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // stimulus and expectation stores
  plf_pkg::in_item_t  pending_words[$];
  plf_pkg::out_item_t cipher_words[$];
  plf_pkg::out_item_t next_cipher;
  logic               no_idle = 1'b0;

  int err_count     = 0;
  int words_taken   = 0;
  int words_checked = 0;
  int planned_words = 0;
  int phase_count   = 0;
  int decipher_runs = 0;
  int cycle_count   = 0;

  // predictor state
  plf_pkg::letter_t sq_letter [plf_pkg::SQ_CELLS];
  int               sq_place  [plf_pkg::ALPHA];
  bit               in_square [plf_pkg::ALPHA];
  int               sq_filled    = 0;
  bit               square_done  = 1'b0;
  plf_pkg::letter_t first_letter = '0;
  bit               first_held   = 1'b0;
  bit               deciphering  = 1'b0;
  plf_pkg::letter_t pad_reg      = plf_pkg::CODE_X;

  playfair_digraph_cipher_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_word   (in_word),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // j shares the place of i
  function automatic plf_pkg::letter_t merge_j(input plf_pkg::letter_t c);
    return (c == plf_pkg::CODE_J) ? plf_pkg::CODE_I : c;
  endfunction

  function automatic plf_pkg::letter_t pad_in_use();
    plf_pkg::letter_t p;
    p = (pad_reg >= plf_pkg::ALPHA) ? plf_pkg::CODE_X : pad_reg;
    return merge_j(p);
  endfunction

  function automatic void square_add(input plf_pkg::letter_t c);
    if (c >= plf_pkg::ALPHA || in_square[c] || sq_filled >= plf_pkg::SQ_CELLS) return;
    sq_letter[sq_filled] = c;
    sq_place[c] = sq_filled;
    in_square[c] = 1'b1;
    sq_filled++;
  endfunction

  // transform one digraph into two expected result words
  function automatic void emit_digraph(input plf_pkg::letter_t a,
                                       input plf_pkg::letter_t b,
                                       input bit last);
    int                 r1, c1, r2, c2, stp;
    plf_pkg::out_item_t w1, w2;
    r1  = sq_place[a] / plf_pkg::SQ_SIDE;
    c1  = sq_place[a] % plf_pkg::SQ_SIDE;
    r2  = sq_place[b] / plf_pkg::SQ_SIDE;
    c2  = sq_place[b] % plf_pkg::SQ_SIDE;
    stp = deciphering ? plf_pkg::SQ_SIDE - 1 : 1;
    if (r1 == r2) begin
      w1.out_letter = sq_letter[r1 * plf_pkg::SQ_SIDE + (c1 + stp) % plf_pkg::SQ_SIDE];
      w2.out_letter = sq_letter[r2 * plf_pkg::SQ_SIDE + (c2 + stp) % plf_pkg::SQ_SIDE];
    end else if (c1 == c2) begin
      w1.out_letter = sq_letter[((r1 + stp) % plf_pkg::SQ_SIDE) * plf_pkg::SQ_SIDE + c1];
      w2.out_letter = sq_letter[((r2 + stp) % plf_pkg::SQ_SIDE) * plf_pkg::SQ_SIDE + c2];
    end else begin
      w1.out_letter = sq_letter[r1 * plf_pkg::SQ_SIDE + c2];
      w2.out_letter = sq_letter[r2 * plf_pkg::SQ_SIDE + c1];
    end
    w1.message_last = 1'b0;
    w2.message_last = last;
    cipher_words.push_back(w1);
    cipher_words.push_back(w2);
  endfunction

  // predictor step for one accepted input word
  function automatic void predict_word(input plf_pkg::in_item_t w);
    plf_pkg::letter_t c;
    int               i;
    c = merge_j(w.letter);
    case (w.action)
      plf_pkg::ACT_KEY: begin
        if (w.letter < plf_pkg::ALPHA) begin
          if (square_done) begin
            for (i = 0; i < plf_pkg::ALPHA; i++) in_square[i] = 1'b0;
            sq_filled    = 0;
            square_done  = 1'b0;
            first_held   = 1'b0;
            first_letter = '0;
          end
          square_add(c);
        end
      end
      plf_pkg::ACT_FINISH: begin
        if (!square_done) begin
          for (i = 0; i < plf_pkg::ALPHA; i++)
            if (plf_pkg::letter_t'(i) != plf_pkg::CODE_J) square_add(plf_pkg::letter_t'(i));
          square_done = 1'b1;
        end
      end
      plf_pkg::ACT_MSG: begin
        if (w.letter < plf_pkg::ALPHA && square_done) begin
          if (!first_held) begin
            first_letter = c;
            first_held   = 1'b1;
          end else if (!deciphering && first_letter == c) begin
            // doubled letter: pad goes between, second letter stays held
            emit_digraph(first_letter, pad_in_use(), 1'b0);
          end else begin
            emit_digraph(first_letter, c, 1'b0);
            first_held   = 1'b0;
            first_letter = '0;
          end
        end
      end
      plf_pkg::ACT_END: begin
        if (square_done && first_held) begin
          emit_digraph(first_letter, pad_in_use(), 1'b1);
          first_held   = 1'b0;
          first_letter = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        predict_word(in_word);
        words_taken++;
      end
      if (!in_push || !in_full) begin
        if (pending_words.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_push <= 1'b1;
          in_word <= pending_words.pop_front();
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (cipher_words.size() == 0) begin
          err_count++;
          $display("%0t ns: expected no word, got letter %0d last %0b", $time,
                   out_word.out_letter, out_word.message_last);
        end else begin
          next_cipher = cipher_words.pop_front();
          words_checked++;
          if (out_word.out_letter !== next_cipher.out_letter) begin
            err_count++;
            $display("%0t ns: out_letter expected %0d, got %0d", $time,
                     next_cipher.out_letter, out_word.out_letter);
          end
          if (out_word.message_last !== next_cipher.message_last) begin
            err_count++;
            $display("%0t ns: message_last expected %0b, got %0b", $time,
                     next_cipher.message_last, out_word.message_last);
          end
        end
      end
      out_pop <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[playfair_digraph_cipher_core] ERROR");
      $finish;
    end
  end

  task automatic put_word(input plf_pkg::action_t a, input plf_pkg::letter_t l);
    plf_pkg::in_item_t w;
    w.action = a;
    w.letter = l;
    pending_words.push_back(w);
    if (a == plf_pkg::ACT_FINISH || a == plf_pkg::ACT_END || l < plf_pkg::ALPHA)
      planned_words++;
  endtask

  // sender holds off until the core has gone quiet
  task automatic wait_quiet();
    while (pending_words.size() != 0 || in_push || cipher_words.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [plf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [plf_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == plf_pkg::REG_DECIPHER) deciphering = val[0];
    else pad_reg = val;
  endtask

  task automatic set_mode_pad(input bit dec, input plf_pkg::letter_t pad);
    wait_quiet();
    write_reg(plf_pkg::REG_DECIPHER, plf_pkg::CFG_DATA_W'(dec));
    write_reg(plf_pkg::REG_PAD, pad);
    phase_count++;
    if (dec) decipher_runs++;
  endtask

  // key words then finish, with repeats and stray codes
  task automatic queue_key();
    int               n, i, roll;
    plf_pkg::letter_t l, prev;
    n    = $urandom_range(0, 14);
    prev = plf_pkg::letter_t'($urandom_range(0, 25));
    for (i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) l = prev;
      else if (roll < 13) l = plf_pkg::letter_t'($urandom_range(26, 31));
      else l = plf_pkg::letter_t'($urandom_range(0, 25));
      put_word(plf_pkg::ACT_KEY, l);
      prev = l;
    end
    put_word(plf_pkg::ACT_FINISH, plf_pkg::letter_t'($urandom_range(0, 31)));
    if ($urandom_range(0, 9) == 0)
      put_word(plf_pkg::ACT_FINISH, plf_pkg::letter_t'($urandom_range(0, 31)));
  endtask

  // message words, leaning on doubles and pad letters
  task automatic queue_message();
    int               n, i, roll;
    plf_pkg::letter_t l, prev;
    n    = $urandom_range(1, 24);
    prev = plf_pkg::letter_t'($urandom_range(0, 25));
    for (i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) l = prev;
      else if (roll < 33) l = pad_in_use();
      else if (roll < 36) l = plf_pkg::letter_t'($urandom_range(26, 31));
      else l = plf_pkg::letter_t'($urandom_range(0, 25));
      // now and then a new key breaks into the message
      if (roll >= 36 && roll < 38) queue_key();
      put_word(plf_pkg::ACT_MSG, l);
      prev = l;
    end
    if ($urandom_range(0, 9) != 0)
      put_word(plf_pkg::ACT_END, plf_pkg::letter_t'($urandom_range(0, 31)));
    if ($urandom_range(0, 14) == 0)
      put_word(plf_pkg::ACT_END, plf_pkg::letter_t'($urandom_range(0, 31)));
  endtask

  // stimulus
  initial begin
    bit               dec;
    plf_pkg::letter_t pad;
    int               phase_no;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: core at reset settings, enciphering with pad x
    put_word(plf_pkg::ACT_MSG, LT_A);
    put_word(plf_pkg::ACT_END, LT_OUT_HI);
    put_word(plf_pkg::ACT_KEY, LT_P);
    put_word(plf_pkg::ACT_KEY, plf_pkg::CODE_J);
    put_word(plf_pkg::ACT_KEY, LT_P);
    put_word(plf_pkg::ACT_KEY, LT_OUT_HI);
    put_word(plf_pkg::ACT_KEY, LT_OUT_LO);
    put_word(plf_pkg::ACT_KEY, LT_Z);
    put_word(plf_pkg::ACT_KEY, LT_A);
    put_word(plf_pkg::ACT_FINISH, LT_A);
    put_word(plf_pkg::ACT_FINISH, LT_Z);
    put_word(plf_pkg::ACT_END, LT_A);
    put_word(plf_pkg::ACT_MSG, LT_A);
    put_word(plf_pkg::ACT_MSG, LT_A);
    put_word(plf_pkg::ACT_MSG, plf_pkg::CODE_J);
    put_word(plf_pkg::ACT_MSG, plf_pkg::CODE_X);
    put_word(plf_pkg::ACT_MSG, plf_pkg::CODE_X);
    put_word(plf_pkg::ACT_END, LT_A);
    put_word(plf_pkg::ACT_MSG, LT_OUT_HI - 5'd1);
    put_word(plf_pkg::ACT_MSG, LT_Z);
    put_word(plf_pkg::ACT_END, LT_Z);

    // directed: deciphering with a pad code above the alphabet
    set_mode_pad(1'b1, LT_OUT_HI);
    put_word(plf_pkg::ACT_MSG, LT_B);
    put_word(plf_pkg::ACT_MSG, LT_B);
    put_word(plf_pkg::ACT_MSG, LT_C);
    put_word(plf_pkg::ACT_END, LT_C);

    // random phases, extreme settings first
    planned_words = 0;
    phase_no = 0;
    while (planned_words < TARGET_WORDS) begin
      case (phase_no)
        0:       begin dec = 1'b0; pad = LT_A;            end
        1:       begin dec = 1'b1; pad = LT_Z;            end
        2:       begin dec = 1'b0; pad = plf_pkg::CODE_J; end
        3:       begin dec = 1'b0; pad = LT_OUT_HI;       end
        default: begin
          dec = 1'($urandom_range(0, 1));
          pad = plf_pkg::letter_t'($urandom_range(0, 31));
        end
      endcase
      set_mode_pad(dec, pad);
      no_idle <= (phase_no == 4 || phase_no == 5);
      queue_key();
      repeat ($urandom_range(2, 5)) queue_message();
      phase_no++;
    end

    wait_quiet();
    $display("run: %0d input words over %0d setting phases (%0d deciphering)",
             words_taken, phase_count, decipher_runs);
    $display("run: %0d results checked; key restarts, doubled and j letters, odd tails, %s",
             words_checked, "stray codes, pads out of range");
    if (err_count == 0 && cipher_words.size() == 0) begin
      $display("[playfair_digraph_cipher_core] OK");
    end else begin
      $display("[playfair_digraph_cipher_core] ERROR");
    end
    $finish;
  end

endmodule
